// ----- rtl/gbr_pkg.sv -----
package gbr_pkg;

    // default sizes
    localparam int HISTORY_BITS_DEF = 12;
    localparam int BTB_ENTRIES_DEF  = 64;
    localparam int STACK_DEPTH_DEF  = 16;

    // func codes
    localparam logic FUNC_PREDICT = 1'b0;
    localparam logic FUNC_UPDATE  = 1'b1;

    // branch kind codes, the unused code acts as conditional
    localparam logic [1:0] KIND_COND   = 2'd0;
    localparam logic [1:0] KIND_CALL   = 2'd1;
    localparam logic [1:0] KIND_RETURN = 2'd2;

    // two-bit direction counter
    typedef logic [1:0] ctr_t;
    localparam ctr_t CTR_MIN         = 2'd0;
    localparam ctr_t CTR_MAX         = 2'd3;
    localparam ctr_t CTR_WEAK_TAKEN  = 2'd2;
    localparam ctr_t CTR_STEP        = 2'd1;

    // item sequencer
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

// ----- rtl/gbr_ram.sv -----
module gbr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/gshare_btb_ras_branch_predictor_unit.sv -----
// result: an accepted word enters the execute state, which registers its result
// flow: no new word is accepted until the last one has left the execute state;
//   the direction counter memory is read on accept and written back in execute
// reset: all control state clears at once, then a clearing pass zeroes all
//   2**HISTORY_BITS counter entries (4096 by default), input stalled
module gshare_btb_ras_branch_predictor_unit #(
    parameter int HISTORY_BITS = gbr_pkg::HISTORY_BITS_DEF,
    parameter int BTB_ENTRIES  = gbr_pkg::BTB_ENTRIES_DEF,
    parameter int STACK_DEPTH  = gbr_pkg::STACK_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [1:0]  branch_kind,
    input  logic [31:0] pc,
    input  logic [31:0] return_addr,
    input  logic        taken,
    input  logic [31:0] actual_target,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        predicted_taken,
    output logic [31:0] predicted_target
);

    import gbr_pkg::*;

    localparam int CTR_ENTRIES = 1 << HISTORY_BITS;
    localparam int BI_W = $clog2(BTB_ENTRIES);
    localparam int SP_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    // control state
    state_t                  state_reg, state_next;
    logic                    clearing_reg;
    logic [HISTORY_BITS-1:0] clr_idx_reg;
    logic [HISTORY_BITS-1:0] hist_reg;
    logic [BI_W-1:0]         victim_reg;
    logic [BTB_ENTRIES-1:0]  valid_reg;
    logic [SP_W-1:0]         top_reg;
    logic [CNT_W-1:0]        count_reg;
    logic                    out_valid_reg;

    // payload state
    logic [31:0]             tags_reg [BTB_ENTRIES];
    logic [31:0]             stack_reg [STACK_DEPTH];
    logic                    func_reg;
    logic [1:0]              kind_reg;
    logic [31:0]             pc_reg;
    logic [31:0]             ret_reg;
    logic                    taken_reg;
    logic [31:0]             actual_reg;
    logic [HISTORY_BITS-1:0] gidx_reg;
    logic                    hit_reg;
    logic [BI_W-1:0]         hit_idx_reg;
    logic                    free_reg;
    logic [BI_W-1:0]         free_idx_reg;
    logic                    pred_taken_reg;
    logic [31:0]             pred_target_reg;

    // handshake and sequencing
    logic                    accept;
    logic                    exec_fire;
    logic                    out_block;

    // lookup
    logic [HISTORY_BITS-1:0] gidx;
    logic                    hit_any;
    logic [BI_W-1:0]         hit_idx;
    logic                    free_any;
    logic [BI_W-1:0]         free_idx;

    // memories
    logic                    ctr_we;
    logic [HISTORY_BITS-1:0] ctr_waddr;
    ctr_t                    ctr_wdata;
    ctr_t                    ctr_rdata;
    ctr_t                    ctr_new;
    logic                    tgt_we;
    logic [BI_W-1:0]         slot;
    logic [31:0]             tgt_rdata;

    // execute results
    logic                    is_update;
    logic                    do_push;
    logic                    do_pop;
    logic [SP_W-1:0]         top_inc;
    logic [SP_W-1:0]         top_dec;
    logic                    res_taken;
    logic [31:0]             res_target;
    logic [31:0]             btb_target;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!out_block)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall  = 1'b1;
        exec_fire = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = clearing_reg;
            end
            ST_EXEC:
            begin
                exec_fire = !out_block;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign out_block = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // counter memory clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == HISTORY_BITS'(CTR_ENTRIES - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // gshare index and parallel tag match on the incoming word
    assign gidx = pc[HISTORY_BITS-1:0] ^ hist_reg;

    always_comb
    begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int i = BTB_ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (tags_reg[i] == pc))
            begin
                hit_any = 1'b1;
                hit_idx = BI_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = BI_W'(i);
            end
        end
    end

    // capture the accepted word and its lookup
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg     <= func;
            kind_reg     <= branch_kind;
            pc_reg       <= pc;
            ret_reg      <= return_addr;
            taken_reg    <= taken;
            actual_reg   <= actual_target;
            gidx_reg     <= gidx;
            hit_reg      <= hit_any;
            hit_idx_reg  <= hit_idx;
            free_reg     <= free_any;
            free_idx_reg <= free_idx;
        end
    end

    // saturating counter update
    always_comb
    begin
        ctr_new = ctr_rdata;
        if (taken_reg)
        begin
            if (ctr_rdata != CTR_MAX)
            begin
                ctr_new = ctr_rdata + CTR_STEP;
            end
        end
        else
        begin
            if (ctr_rdata != CTR_MIN)
            begin
                ctr_new = ctr_rdata - CTR_STEP;
            end
        end
    end

    assign is_update = exec_fire && (func_reg == FUNC_UPDATE);
    assign ctr_we    = clearing_reg || is_update;
    assign ctr_waddr = clearing_reg ? clr_idx_reg : gidx_reg;
    assign ctr_wdata = clearing_reg ? CTR_MIN : ctr_new;

    gbr_ram #(
        .WIDTH ($bits(ctr_t)),
        .DEPTH (CTR_ENTRIES)
    ) u_ctr_ram (
        .clk   (clk),
        .we    (ctr_we),
        .waddr (ctr_waddr),
        .wdata (ctr_wdata),
        .re    (accept),
        .raddr (gidx),
        .rdata (ctr_rdata)
    );

    // btb slot choice: matching entry, first free, then round robin victim
    always_comb
    begin
        if (hit_reg)
        begin
            slot = hit_idx_reg;
        end
        else if (free_reg)
        begin
            slot = free_idx_reg;
        end
        else
        begin
            slot = victim_reg;
        end
    end

    assign tgt_we = is_update;

    gbr_ram #(
        .WIDTH (32),
        .DEPTH (BTB_ENTRIES)
    ) u_tgt_ram (
        .clk   (clk),
        .we    (tgt_we),
        .waddr (slot),
        .wdata (actual_reg),
        .re    (accept),
        .raddr (hit_idx),
        .rdata (tgt_rdata)
    );

    // btb tags, valid bits and victim pointer
    always_ff @(posedge clk)
    begin
        if (is_update)
        begin
            tags_reg[slot] <= pc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            victim_reg <= '0;
            hist_reg   <= '0;
        end
        else if (is_update)
        begin
            valid_reg[slot] <= 1'b1;
            hist_reg        <= {hist_reg[HISTORY_BITS-2:0], taken_reg};
            if (!hit_reg && !free_reg)
            begin
                if (victim_reg == BI_W'(BTB_ENTRIES - 1))
                begin
                    victim_reg <= '0;
                end
                else
                begin
                    victim_reg <= victim_reg + 1'b1;
                end
            end
        end
    end

    // return stack pointers
    assign top_inc = (top_reg == SP_W'(STACK_DEPTH - 1)) ? '0 : top_reg + 1'b1;
    assign top_dec = (top_reg == '0) ? SP_W'(STACK_DEPTH - 1) : top_reg - 1'b1;
    assign do_push = exec_fire && (func_reg == FUNC_PREDICT) && (kind_reg == KIND_CALL);
    assign do_pop  = exec_fire && (func_reg == FUNC_PREDICT) && (kind_reg == KIND_RETURN)
                     && (count_reg != '0);

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            stack_reg[top_inc] <= ret_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg   <= '0;
            count_reg <= '0;
        end
        else if (do_push)
        begin
            top_reg <= top_inc;
            if (count_reg != CNT_W'(STACK_DEPTH))
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
        else if (do_pop)
        begin
            top_reg   <= top_dec;
            count_reg <= count_reg - 1'b1;
        end
    end

    // prediction result
    assign btb_target = hit_reg ? tgt_rdata : pc_reg;

    always_comb
    begin
        res_taken  = 1'b0;
        res_target = '0;
        if (func_reg == FUNC_PREDICT)
        begin
            case (kind_reg)
                KIND_CALL:
                begin
                    res_taken  = 1'b1;
                    res_target = btb_target;
                end
                KIND_RETURN:
                begin
                    res_taken  = 1'b1;
                    res_target = (count_reg != '0) ? stack_reg[top_reg] : pc_reg;
                end
                default:
                begin
                    if (ctr_rdata >= CTR_WEAK_TAKEN)
                    begin
                        res_taken  = 1'b1;
                        res_target = btb_target;
                    end
                    else
                    begin
                        res_target = pc_reg;
                    end
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            pred_taken_reg  <= res_taken;
            pred_target_reg <= res_target;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (exec_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign predicted_taken  = pred_taken_reg;
    assign predicted_target = pred_target_reg;

`ifndef SYNTHESIS
    // a new result word only comes out of the execute cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EXEC))
        else $error("result word without execute cycle");

    // return stack occupancy stays within its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("return stack count overflow");

    // victim pointer stays inside the btb
    assert property (@(posedge clk) disable iff (!rst_n)
        victim_reg <= BI_W'(BTB_ENTRIES - 1))
        else $error("victim pointer out of range");

    // an update shifts its resolved direction into the history
    assert property (@(posedge clk) disable iff (!rst_n)
        is_update |=> (hist_reg[0] == $past(taken_reg)))
        else $error("history not shifted on update");
`endif

endmodule
